@@ hdl/u8sd_pkg.sv @@
`default_nettype none

package u8sd_pkg;

    // Replacement character emitted for every rejected byte.
    localparam logic [20:0] REPL_CP = 21'h00FFFD;

    // Upper bound and sub-ranges used by the sequence checks.
    localparam logic [20:0] MIN_CP_2B   = 21'h000080;
    localparam logic [20:0] MIN_CP_3B   = 21'h000800;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] MIN_CP_4B   = 21'h010000;
    localparam logic [20:0] MAX_CP      = 21'h10FFFF;

    // One queued job: a run of replacement words followed by an optional
    // tail word. A job always describes at least one word.
    typedef struct packed {
        logic [1:0]  rep_count;
        logic        has_tail;
        logic [20:0] tail_cp;
        logic [2:0]  tail_seq;
        logic        tail_replaced;
        logic        tail_at_end;
    } job_t;

    // Classification of a byte seen with no sequence pending.
    typedef struct packed {
        logic        has_result;
        logic [20:0] code_point;
        logic [2:0]  seq_bytes;
        logic        replaced;
        logic        at_end;
        logic        is_lead;
        logic [1:0]  need;
    } lead_class_t;

endpackage

`default_nettype wire

@@ hdl/u8sd_front.sv @@
`default_nettype none

module u8sd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire logic [7:0]    in_byte,
    output logic               job_valid,
    output u8sd_pkg::job_t     job
);

    logic [7:0] lead_reg, lead_next;
    logic [5:0] cont_reg [2];
    logic [1:0] need_reg, need_next;
    logic [1:0] have_reg, have_next;
    logic       cont_we;

    u8sd_pkg::lead_class_t lc;
    logic        is_cont;
    logic [5:0]  cl;
    logic [20:0] seq_cp;
    logic        seq_ok;

    function automatic u8sd_pkg::lead_class_t classify(input logic [7:0] b);
        u8sd_pkg::lead_class_t r;
        r = '0;
        if (b == 8'h00) begin
            r.has_result = 1'b1;
            r.at_end     = 1'b1;
        end
        else if (b[7] == 1'b0) begin
            r.has_result = 1'b1;
            r.code_point = {13'd0, b};
            r.seq_bytes  = 3'd1;
        end
        else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
            r.has_result = 1'b1;
            r.code_point = u8sd_pkg::REPL_CP;
            r.seq_bytes  = 3'd1;
            r.replaced   = 1'b1;
        end
        else begin
            r.is_lead = 1'b1;
            if (b[5] == 1'b0) begin
                r.need = 2'd1;
            end
            else if (b[4] == 1'b0) begin
                r.need = 2'd2;
            end
            else begin
                r.need = 2'd3;
            end
        end
        return r;
    endfunction

    always_comb begin
        lc      = classify(in_byte);
        is_cont = (in_byte[7:6] == 2'b10);
        cl      = in_byte[5:0];

        case (need_reg)
            2'd1: begin
                seq_cp = {10'd0, lead_reg[4:0], cl};
                seq_ok = (seq_cp >= u8sd_pkg::MIN_CP_2B);
            end
            2'd2: begin
                seq_cp = {5'd0, lead_reg[3:0], cont_reg[0], cl};
                seq_ok = (seq_cp >= u8sd_pkg::MIN_CP_3B)
                      && !(seq_cp >= u8sd_pkg::SURR_LO && seq_cp <= u8sd_pkg::SURR_HI);
            end
            default: begin
                seq_cp = {lead_reg[2:0], cont_reg[0], cont_reg[1], cl};
                seq_ok = (seq_cp >= u8sd_pkg::MIN_CP_4B) && (seq_cp <= u8sd_pkg::MAX_CP);
            end
        endcase
    end

    always_comb begin
        job       = '0;
        job_valid = 1'b0;
        lead_next = lead_reg;
        need_next = need_reg;
        have_next = have_reg;
        cont_we   = 1'b0;

        if (need_reg == 2'd0 || !is_cont) begin
            // Either nothing is pending, or the pending sequence is broken:
            // replace the lead and each buffered byte, then treat the new
            // byte as a fresh lead.
            if (need_reg != 2'd0) begin
                job.rep_count = have_reg + 2'd1;
                job_valid     = 1'b1;
            end
            need_next = 2'd0;
            have_next = 2'd0;
            if (lc.has_result) begin
                job_valid         = 1'b1;
                job.has_tail      = 1'b1;
                job.tail_cp       = lc.code_point;
                job.tail_seq      = lc.seq_bytes;
                job.tail_replaced = lc.replaced;
                job.tail_at_end   = lc.at_end;
            end
            if (lc.is_lead) begin
                lead_next = in_byte;
                need_next = lc.need;
            end
        end
        else if (have_reg + 2'd1 < need_reg) begin
            cont_we   = 1'b1;
            have_next = have_reg + 2'd1;
        end
        else begin
            need_next    = 2'd0;
            have_next    = 2'd0;
            job_valid    = 1'b1;
            job.has_tail = 1'b1;
            if (seq_ok) begin
                job.tail_cp  = seq_cp;
                job.tail_seq = {1'b0, need_reg} + 3'd1;
            end
            else begin
                // Value out of range: the closing byte is replaced too.
                job.rep_count     = have_reg + 2'd1;
                job.tail_cp       = u8sd_pkg::REPL_CP;
                job.tail_seq      = 3'd1;
                job.tail_replaced = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lead_reg <= 8'd0;
            need_reg <= 2'd0;
            have_reg <= 2'd0;
        end
        else if (take) begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk) begin
        if (take && cont_we) begin
            cont_reg[have_reg[0]] <= cl;
        end
    end

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        need_reg == 2'd0 |-> have_reg == 2'd0)
        else $error("continuation bytes buffered with no lead pending");

    a_have_below_need: assert property (@(posedge clk) disable iff (!rst_n)
        need_reg != 2'd0 |-> have_reg < need_reg)
        else $error("buffered count reached the sequence length");

endmodule

`default_nettype wire

@@ hdl/u8sd_queue.sv @@
`default_nettype none

module u8sd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire u8sd_pkg::job_t push_job,
    input  wire logic           pop,
    output u8sd_pkg::job_t      head_job,
    output logic                head_valid,
    output logic                full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    u8sd_pkg::job_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("job queue count beyond its depth");

endmodule

`default_nettype wire

@@ hdl/u8sd_back.sv @@
`default_nettype none

module u8sd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire u8sd_pkg::job_t head_job,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [20:0]         code_point,
    output logic [2:0]          seq_bytes,
    output logic                replaced,
    output logic                at_end,
    output logic                last_of_run
);

    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    logic [20:0] cp_reg;
    logic [2:0]  seq_reg;
    logic        rep_reg, end_reg, last_reg;

    logic [2:0]  total;
    logic        is_last, load, in_rep;

    always_comb begin
        total   = {1'b0, head_job.rep_count} + {2'd0, head_job.has_tail};
        is_last = ({1'b0, idx_reg} == total - 3'd1);
        in_rep  = (idx_reg < head_job.rep_count);
        load    = head_valid && (!out_valid_reg || !out_stall);
        pop     = load && is_last;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            last_reg <= is_last;
            if (in_rep) begin
                cp_reg  <= u8sd_pkg::REPL_CP;
                seq_reg <= 3'd1;
                rep_reg <= 1'b1;
                end_reg <= 1'b0;
            end
            else begin
                cp_reg  <= head_job.tail_cp;
                seq_reg <= head_job.tail_seq;
                rep_reg <= head_job.tail_replaced;
                end_reg <= head_job.tail_at_end;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = cp_reg;
    assign seq_bytes   = seq_reg;
    assign replaced    = rep_reg;
    assign at_end      = end_reg;
    assign last_of_run = last_reg;

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> head_valid)
        else $error("job left the queue before all its words were sent");

endmodule

`default_nettype wire

@@ hdl/utf8_stream_decoder_core.sv @@
`default_nettype none

// Channel | Role   | Handshake             | Word fields
// --------+--------+-----------------------+------------------------------------------------
// in      | sink   | in_valid / in_stall   | in_byte
// out     | source | out_valid / out_stall | code_point, seq_bytes, replaced, at_end, last_of_run
//
// A byte is taken at every edge at which the job queue has room, so bytes can follow
// back to back. Its job is queued at that same edge and, with the queue empty and the
// output register free, its first word is presented right after the next edge.
// A byte causes zero to four words and the output sends one word per cycle while out_stall is low.
// Reset clears the pending sequence, the job queue and the output valid flag.
// in_stall rises only while the job queue is full; out_stall holds the current word.

module utf8_stream_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [20:0]      code_point,
    output logic [2:0]       seq_bytes,
    output logic             replaced,
    output logic             at_end,
    output logic             last_of_run
);

    // The front end holds the pending lead and continuation bytes and turns
    // each accepted byte into at most one job. A job is a count of
    // replacement words plus an optional final word, so a broken sequence
    // never needs more than one queue entry.
    logic           take;
    logic           job_valid;
    u8sd_pkg::job_t job;

    // Queue between front and back so that a burst of replacement words
    // does not stall the byte stream at once.
    u8sd_pkg::job_t head_job;
    logic           head_valid;
    logic           queue_full;
    logic           pop;

    assign in_stall = queue_full;
    assign take     = in_valid && !queue_full;

    u8sd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .job_valid (job_valid),
        .job       (job)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take && job_valid),
        .push_job   (job),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    // The back end expands the head job into words, one per cycle while out_stall
    // is low, through a single output register.
    u8sd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .seq_bytes   (seq_bytes),
        .replaced    (replaced),
        .at_end      (at_end),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
